/* hw/rtl/adaptive_link_poll_scheduler_core_macros.svh */
// assertion macros for the adaptive link poll scheduler checker
// no dependencies; included by the checker file only
`ifndef ADAPTIVE_LINK_POLL_SCHEDULER_CORE_MACROS_SVH
`define ADAPTIVE_LINK_POLL_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ALPS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alps assertion failed");

// next-cycle implication, disabled during reset
`define ALPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alps assertion failed");

// next-cycle implication that also holds across reset
`define ALPS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("alps assertion failed");

`endif

/* hw/rtl/alps_pkg.sv */
// shared types and constants for the adaptive link poll scheduler
// no dependencies; used by every rtl module of the block
`default_nettype none

package alps_pkg;

   // downlink lanes and interval ceiling
   localparam int NUM_LINKS    = 8;
   localparam int MAX_INTERVAL = 64;

   // fixed field widths
   localparam int DL_WIDTH     = 8;
   localparam int CNT_WIDTH    = 7;
   localparam int PERIOD_WIDTH = 16;
   localparam int ACTIVE_WIDTH = 4;
   localparam int LINK_IDX_WIDTH = 3;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // reset values of the configuration registers
   localparam logic [PERIOD_WIDTH-1:0] SYNC_ALL_PERIOD_RESET = PERIOD_WIDTH'(1000);

   typedef enum logic [1:0] {
      ACT_TICK_1MS  = 2'd0,
      ACT_TICK_10MS = 2'd1,
      ACT_TRAFFIC   = 2'd2,
      ACT_UNUSED    = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SYNC_ALL_PERIOD  = 2'd0,
      CSR_ACTIVE_LINKS     = 2'd1,
      CSR_UPLINK_PRESENT   = 2'd2,
      CSR_SIDELINK_PRESENT = 2'd3
   } csr_index_type;

   typedef struct packed {
      action_type                action;
      logic [LINK_IDX_WIDTH-1:0] link_index;
      logic [DL_WIDTH-1:0]       downlink_online;
      logic                      uplink_online;
      logic                      sidelink_online;
   } req_type;

   typedef struct packed {
      logic [DL_WIDTH-1:0] downlink_sync;
      logic                uplink_sync;
      logic                sidelink_sync;
      logic                sync_all;
   } rsp_type;

   // per-request control broadcast to every lane
   typedef struct packed {
      logic tick_1ms;
      logic tick_10ms;
      logic sync_all;
   } lane_ctl_type;

   // per-request control for the merge stage
   typedef struct packed {
      logic accept;
      logic tick_1ms;
      logic sync_all;
      logic uplink_present;
      logic uplink_online;
      logic sidelink_present;
      logic sidelink_online;
   } merge_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/alps_lane.sv */
// one downlink lane: countdown, poll interval and grace bit of one link
// depends on alps_pkg
`default_nettype none

module alps_lane (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alps_pkg::lane_ctl_type ctl,
   input  wire logic                  active,
   input  wire logic                  restart,
   input  wire logic                  online,
   output logic                       poll
);

   logic [alps_pkg::CNT_WIDTH-1:0] countdown_ff, countdown_in;
   logic [alps_pkg::CNT_WIDTH-1:0] interval_ff, interval_in;
   logic                           grace_ff, grace_in;
   logic [alps_pkg::CNT_WIDTH-1:0] count_dec;

   // countdown, interval growth and traffic restart
   always_comb begin
      countdown_in = countdown_ff;
      interval_in  = interval_ff;
      grace_in     = grace_ff;
      poll         = 1'b0;
      count_dec    = (countdown_ff != '0) ? countdown_ff - 1'b1 : countdown_ff;
      if (ctl.tick_1ms && active) begin
         if (count_dec == '0) begin
            countdown_in = interval_ff;
            poll         = ctl.sync_all || online;
         end else begin
            countdown_in = count_dec;
            poll         = ctl.sync_all;
         end
      end else if (ctl.tick_10ms && active) begin
         if (grace_ff) begin
            grace_in = 1'b0;
         end else if (interval_ff < alps_pkg::CNT_WIDTH'(alps_pkg::MAX_INTERVAL)) begin
            interval_in = {interval_ff[alps_pkg::CNT_WIDTH-2:0], 1'b0};
         end
      end else if (restart) begin
         countdown_in = '0;
         interval_in  = alps_pkg::CNT_WIDTH'(1);
         grace_in     = 1'b1;
      end
   end

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
         interval_ff  <= alps_pkg::CNT_WIDTH'(1);
         grace_ff     <= 1'b1;
      end else begin
         countdown_ff <= countdown_in;
         interval_ff  <= interval_in;
         grace_ff     <= grace_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/alps_merge.sv */
// merge stage: gathers lane polls, adds uplink and sidelink, holds the response
// depends on alps_pkg
`default_nettype none

module alps_merge (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire alps_pkg::merge_ctl_type           ctl,
   input  wire logic [alps_pkg::NUM_LINKS-1:0]    lane_poll,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output alps_pkg::rsp_type                      rsp_data
);

   logic [alps_pkg::DL_WIDTH-1:0] dl_poll;
   alps_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // lanes beyond the reported width are dropped, missing lanes read as zero
   for (genvar i = 0; i < alps_pkg::DL_WIDTH; i++) begin : g_bit
      if (i < alps_pkg::NUM_LINKS) begin : g_lane
         assign dl_poll[i] = lane_poll[i];
      end else begin : g_none
         assign dl_poll[i] = 1'b0;
      end
   end

   // response word for the accepted request
   always_comb begin
      rsp_in.downlink_sync = dl_poll;
      rsp_in.uplink_sync   = ctl.tick_1ms && ctl.uplink_present &&
                             (ctl.uplink_online || ctl.sync_all);
      rsp_in.sidelink_sync = ctl.tick_1ms && ctl.sidelink_present &&
                             (ctl.sidelink_online || ctl.sync_all);
      rsp_in.sync_all      = ctl.sync_all;
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/adaptive_link_poll_scheduler_core.sv */
// adaptive link poll scheduler: one lane per downlink plus a merge stage.
// the response is registered and appears in the cycle after its request is accepted.
// throughput: one request per cycle while responses are taken; all lanes update in the
// accept cycle, and the response register takes the next request while the last is taken.
// reset (synchronous, active high) loads register defaults, zero countdowns,
// interval one with grace set, and empties the response register.
`default_nettype none

module adaptive_link_poll_scheduler_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire alps_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output alps_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [alps_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  wire logic [alps_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   logic [alps_pkg::PERIOD_WIDTH-1:0] period_ff, period_in;
   logic [alps_pkg::ACTIVE_WIDTH-1:0] active_links_ff, active_links_in;
   logic                              uplink_present_ff, uplink_present_in;
   logic                              sidelink_present_ff, sidelink_present_in;
   logic [alps_pkg::PERIOD_WIDTH-1:0] sync_cd_ff, sync_cd_in;

   logic                              accept;
   logic                              tick_1ms;
   logic                              sync_all;
   alps_pkg::lane_ctl_type            lane_ctl;
   alps_pkg::merge_ctl_type           merge_ctl;
   logic [alps_pkg::NUM_LINKS-1:0]    lane_poll;

   // handshakes
   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration writes
   always_comb begin
      period_in           = period_ff;
      active_links_in     = active_links_ff;
      uplink_present_in   = uplink_present_ff;
      sidelink_present_in = sidelink_present_ff;
      if (csr_valid) begin
         case (alps_pkg::csr_index_type'(csr_index))
            alps_pkg::CSR_SYNC_ALL_PERIOD:  period_in = csr_data;
            alps_pkg::CSR_ACTIVE_LINKS:
               active_links_in = csr_data[alps_pkg::ACTIVE_WIDTH-1:0];
            alps_pkg::CSR_UPLINK_PRESENT:   uplink_present_in = csr_data[0];
            alps_pkg::CSR_SIDELINK_PRESENT: sidelink_present_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff           <= alps_pkg::SYNC_ALL_PERIOD_RESET;
         active_links_ff     <= '0;
         uplink_present_ff   <= 1'b0;
         sidelink_present_ff <= 1'b0;
      end else begin
         period_ff           <= period_in;
         active_links_ff     <= active_links_in;
         uplink_present_ff   <= uplink_present_in;
         sidelink_present_ff <= sidelink_present_in;
      end
   end

   // sync-all countdown
   assign tick_1ms = accept && (req_data.action == alps_pkg::ACT_TICK_1MS);
   assign sync_all = tick_1ms && (sync_cd_ff == '0);

   always_comb begin
      sync_cd_in = sync_cd_ff;
      if (sync_all) begin
         sync_cd_in = period_ff;
      end else if (tick_1ms) begin
         sync_cd_in = sync_cd_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_cd_ff <= '0;
      end else begin
         sync_cd_ff <= sync_cd_in;
      end
   end

   // lane broadcast
   assign lane_ctl.tick_1ms  = tick_1ms;
   assign lane_ctl.tick_10ms = accept && (req_data.action == alps_pkg::ACT_TICK_10MS);
   assign lane_ctl.sync_all  = sync_all;

   for (genvar i = 0; i < alps_pkg::NUM_LINKS; i++) begin : g_lane
      logic lane_active;
      logic lane_restart;
      logic lane_online;

      // a lane is in use below active_links; larger settings cover every lane
      assign lane_active  = {1'b0, active_links_ff} > 5'(i);
      assign lane_restart = accept && (req_data.action == alps_pkg::ACT_TRAFFIC) &&
                            (5'(req_data.link_index) == 5'(i));
      if (i < alps_pkg::DL_WIDTH) begin : g_on
         assign lane_online = req_data.downlink_online[i];
      end else begin : g_off
         assign lane_online = 1'b0;
      end

      alps_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (lane_ctl),
         .active  (lane_active),
         .restart (lane_restart),
         .online  (lane_online),
         .poll    (lane_poll[i])
      );
   end

   // merge and response register
   assign merge_ctl.accept           = accept;
   assign merge_ctl.tick_1ms         = tick_1ms;
   assign merge_ctl.sync_all         = sync_all;
   assign merge_ctl.uplink_present   = uplink_present_ff;
   assign merge_ctl.uplink_online    = req_data.uplink_online;
   assign merge_ctl.sidelink_present = sidelink_present_ff;
   assign merge_ctl.sidelink_online  = req_data.sidelink_online;

   alps_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (merge_ctl),
      .lane_poll (lane_poll),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hw/rtl/alps_checker.sv */
// port-level checker for the adaptive link poll scheduler, bound to the top level
// depends on alps_pkg and adaptive_link_poll_scheduler_core_macros.svh
`default_nettype none
`include "adaptive_link_poll_scheduler_core_macros.svh"

module alps_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire alps_pkg::rsp_type rsp_data,
   input wire logic              csr_valid,
   input wire logic              csr_ready
);

   // response register is empty right after reset
   `ALPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // an accepted request shows its response in the next cycle
   `ALPS_ASSERT_NEXT(a_one_cycle, clock, reset, req_valid && req_ready, rsp_valid)

   // configuration writes are never stalled
   `ALPS_ASSERT_SAME(a_csr_ready, clock, reset, csr_valid, csr_ready)

   // a stalled response holds
   `ALPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_data))

endmodule

bind adaptive_link_poll_scheduler_core alps_checker u_alps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

`default_nettype wire

/* verif/tb.sv */
// testbench for adaptive_link_poll_scheduler_core: directed corners, then random requests
// under changing link setups, each response checked against an in-bench poll predictor
// depends on alps_pkg and adaptive_link_poll_scheduler_core
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int CHUNK_LEN   = 50;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   alps_pkg::req_type                   req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   alps_pkg::rsp_type                   rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [alps_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [alps_pkg::CSR_DATA_WIDTH-1:0] csr_data  = '0;

   // predictor copy of the link setup registers
   logic [alps_pkg::PERIOD_WIDTH-1:0] cfg_period   = alps_pkg::SYNC_ALL_PERIOD_RESET;
   logic [alps_pkg::ACTIVE_WIDTH-1:0] cfg_active   = '0;
   logic                              cfg_uplink   = 1'b0;
   logic                              cfg_sidelink = 1'b0;

   // predictor copy of the poll schedule
   logic [alps_pkg::PERIOD_WIDTH-1:0] sync_all_left = '0;
   logic [alps_pkg::CNT_WIDTH-1:0]    poll_countdown [alps_pkg::NUM_LINKS] = '{default: '0};
   logic [alps_pkg::CNT_WIDTH-1:0]    poll_interval  [alps_pkg::NUM_LINKS] =
      '{default: alps_pkg::CNT_WIDTH'(1)};
   logic                              poll_grace     [alps_pkg::NUM_LINKS] = '{default: 1'b1};

   // polls predicted for accepted requests, oldest first
   alps_pkg::rsp_type pending_polls [$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_off_left = 0;

   adaptive_link_poll_scheduler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // work out the polls for one request and advance the schedule
   function automatic alps_pkg::rsp_type schedule_poll(input alps_pkg::req_type r);
      alps_pkg::rsp_type res;
      int                lanes;
      logic              due;
      res   = '0;
      lanes = (cfg_active > alps_pkg::NUM_LINKS) ? alps_pkg::NUM_LINKS : int'(cfg_active);
      case (r.action)
         alps_pkg::ACT_TICK_1MS: begin
            if (sync_all_left == '0) begin
               res.sync_all  = 1'b1;
               sync_all_left = cfg_period;
            end else begin
               sync_all_left = sync_all_left - 1'b1;
            end
            for (int i = 0; i < lanes; i++) begin
               due = res.sync_all;
               if (poll_countdown[i] != '0) begin
                  poll_countdown[i] = poll_countdown[i] - 1'b1;
               end
               if (poll_countdown[i] == '0) begin
                  poll_countdown[i] = poll_interval[i];
                  due               = 1'b1;
               end
               res.downlink_sync[i] = due && (r.downlink_online[i] || res.sync_all);
            end
            res.uplink_sync   = cfg_uplink && (r.uplink_online || res.sync_all);
            res.sidelink_sync = cfg_sidelink && (r.sidelink_online || res.sync_all);
         end
         alps_pkg::ACT_TICK_10MS: begin
            // grace first, then double up to the ceiling
            for (int i = 0; i < lanes; i++) begin
               if (poll_grace[i]) begin
                  poll_grace[i] = 1'b0;
               end else if (poll_interval[i] < alps_pkg::MAX_INTERVAL) begin
                  poll_interval[i] = poll_interval[i] << 1;
               end
            end
         end
         alps_pkg::ACT_TRAFFIC: begin
            // any index restarts its link, active or not
            poll_countdown[r.link_index] = '0;
            poll_interval[r.link_index]  = alps_pkg::CNT_WIDTH'(1);
            poll_grace[r.link_index]     = 1'b1;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("tb: error at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // compare responses, record requests and register writes
   always @(posedge clock) begin : monitor
      alps_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_polls.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = pending_polls.pop_front();
               if (rsp_data.downlink_sync !== want.downlink_sync)
                  report_error($sformatf("downlink_sync got %h want %h",
                                         rsp_data.downlink_sync, want.downlink_sync));
               if (rsp_data.uplink_sync !== want.uplink_sync)
                  report_error($sformatf("uplink_sync got %b want %b",
                                         rsp_data.uplink_sync, want.uplink_sync));
               if (rsp_data.sidelink_sync !== want.sidelink_sync)
                  report_error($sformatf("sidelink_sync got %b want %b",
                                         rsp_data.sidelink_sync, want.sidelink_sync));
               if (rsp_data.sync_all !== want.sync_all)
                  report_error($sformatf("sync_all got %b want %b",
                                         rsp_data.sync_all, want.sync_all));
            end
         end
         if (req_valid && req_ready) begin
            pending_polls.push_back(schedule_poll(req_data));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               alps_pkg::CSR_SYNC_ALL_PERIOD:
                  cfg_period = csr_data[alps_pkg::PERIOD_WIDTH-1:0];
               alps_pkg::CSR_ACTIVE_LINKS:
                  cfg_active = csr_data[alps_pkg::ACTIVE_WIDTH-1:0];
               alps_pkg::CSR_UPLINK_PRESENT:   cfg_uplink   = csr_data[0];
               alps_pkg::CSR_SIDELINK_PRESENT: cfg_sidelink = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // response side: random stalls, or a long hold-off when one is pending
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // offer one request; valid stays high afterwards until the next call or a drain
   task automatic send_request(input alps_pkg::req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop sending and wait until every predicted poll has been checked
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_polls.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input alps_pkg::csr_index_type idx,
                            input logic [alps_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // rewrite all four registers once the block is idle
   task automatic program_links(input logic [alps_pkg::CSR_DATA_WIDTH-1:0] period, active,
                                input logic [alps_pkg::CSR_DATA_WIDTH-1:0] uplink, sidelink);
      wait_for_idle();
      write_csr(alps_pkg::CSR_SYNC_ALL_PERIOD, period);
      write_csr(alps_pkg::CSR_ACTIVE_LINKS, active);
      write_csr(alps_pkg::CSR_UPLINK_PRESENT, uplink);
      write_csr(alps_pkg::CSR_SIDELINK_PRESENT, sidelink);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic alps_pkg::req_type make_request(input alps_pkg::action_type act,
                                                      input logic [2:0] idx,
                                                      input logic [7:0] online,
                                                      input logic up,
                                                      input logic side);
      alps_pkg::req_type r;
      r.action          = act;
      r.link_index      = idx;
      r.downlink_online = online;
      r.uplink_online   = up;
      r.sidelink_online = side;
      return r;
   endfunction

   // mostly 1 ms ticks, enough 10 ms ticks to reach the interval ceiling
   function automatic alps_pkg::req_type random_request();
      alps_pkg::req_type r;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 55)      r.action = alps_pkg::ACT_TICK_1MS;
      else if (pick < 75) r.action = alps_pkg::ACT_TICK_10MS;
      else if (pick < 95) r.action = alps_pkg::ACT_TRAFFIC;
      else                r.action = alps_pkg::ACT_UNUSED;
      r.link_index = 3'($urandom_range(7));
      pick = $urandom_range(9);
      if (pick == 0)      r.downlink_online = '1;
      else if (pick == 1) r.downlink_online = '0;
      else                r.downlink_online = 8'($urandom);
      r.uplink_online   = 1'($urandom);
      r.sidelink_online = 1'($urandom);
      return r;
   endfunction

   // register defaults: first tick is a sync-all with nothing attached
   task automatic test_reset_state();
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_TICK_10MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_UNUSED, 3'd7, 8'hFF, 1'b1, 1'b1));
   endtask

   // online filter, grace and doubling, traffic restart, unused action,
   // period and active-link extremes, traffic to an inactive link
   task automatic test_directed_corners();
      program_links(16'd2, 16'd8, 16'd1, 16'd1);
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h55, 1'b1, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'hAA, 1'b0, 1'b1));
      send_request(make_request(alps_pkg::ACT_TRAFFIC, 3'd7, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_TRAFFIC, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h81, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_UNUSED, 3'd7, 8'hFF, 1'b1, 1'b1));
      // sync-all on every tick, more active links than lanes, upper write bits ignored
      program_links(16'h0000, 16'hFFFF, 16'hFFFE, 16'hFFFF);
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h0F, 1'b1, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'hF0, 1'b0, 1'b1));
      // longest period; traffic to a link beyond the active ones
      program_links(16'hFFFF, 16'd2, 16'd1, 16'd0);
      send_request(make_request(alps_pkg::ACT_TRAFFIC, 3'd5, 8'hFF, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_TICK_10MS, 3'd0, 8'h00, 1'b0, 1'b0));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h03, 1'b1, 1'b1));
      send_request(make_request(alps_pkg::ACT_TICK_1MS, 3'd0, 8'h00, 1'b1, 1'b0));
   endtask

   // chunks of random requests, each under a fresh random link setup
   task automatic test_random_mix(input int chunks, input int sender_pct, input int receiver_pct);
      logic [alps_pkg::PERIOD_WIDTH-1:0] period;
      logic [alps_pkg::ACTIVE_WIDTH-1:0] active;
      int                                pick;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      repeat (chunks) begin
         pick = $urandom_range(9);
         if (pick == 0)      period = '0;
         else if (pick == 1) period = '1;
         else if (pick == 2) period = 16'($urandom);
         else                period = 16'($urandom_range(12, 1));
         pick = $urandom_range(9);
         if (pick < 6)       active = 4'd8;
         else if (pick == 6) active = 4'($urandom_range(15, 9));
         else                active = 4'($urandom_range(7));
         program_links(period, {12'($urandom), active}, 16'($urandom), 16'($urandom));
         repeat (CHUNK_LEN) send_request(random_request());
      end
      wait_for_idle();
   endtask

   // receiver holds off while requests keep coming, so the input backs up
   task automatic test_receiver_hold_off();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      program_links(16'd7, 16'd8, 16'd1, 16'd1);
      hold_off_left = 400;
      repeat (40) send_request(random_request());
      wait_for_idle();
   endtask

   // sender pauses until every poll is back, then resumes on the same setup
   task automatic test_drain_pause();
      send_idle_pct = 33;
      rsp_idle_pct  = 33;
      repeat (12) send_request(random_request());
      wait_for_idle();
      repeat (12) send_request(random_request());
      wait_for_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed_corners();
      test_random_mix(10, 33, 79);
      test_random_mix(10, 79, 33);
      test_receiver_hold_off();
      test_drain_pause();
      test_random_mix(8, 0, 0);
      wait_for_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
